@@ sv/lcfdu_pkg.sv @@
// shared types, codes and saturating helpers for the lifted cut factor dual update block
`default_nettype none

package lcfdu_pkg;

    localparam int MAX_CUT_EDGES_DEF    = 16;
    localparam int MAX_LIFTED_EDGES_DEF = 16;

    // width that holds any edge count up to the largest allowed depth
    localparam int CNT_W = 9;

    localparam logic [1:0] OP_CUT_UPD  = 2'd0;
    localparam logic [1:0] OP_LIFT_UPD = 2'd1;
    localparam logic [1:0] OP_CUT_BP   = 2'd2;
    localparam logic [1:0] OP_LIFT_BP  = 2'd3;

    localparam logic CFG_CUT_COUNT  = 1'b0;
    localparam logic CFG_LIFT_COUNT = 1'b1;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_STAT,
        ST_SCAN,
        ST_SCAN_END,
        ST_FIX,
        ST_BOUND
    } state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic add;
        logic stat;
        logic scan;
        logic fix;
        logic bound;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } status_t;

    function automatic logic ovf34(input logic signed [33:0] v);
        return (v > 34'(Q_MAX)) || (v < 34'(Q_MIN));
    endfunction

    function automatic logic signed [31:0] clip34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'(Q_MAX))
            r = Q_MAX;
        else if (v < 34'(Q_MIN))
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] min0(input logic signed [31:0] v);
        return (v < 32'sd0) ? v : 32'sd0;
    endfunction

    function automatic logic signed [31:0] max0(input logic signed [31:0] v);
        return (v > 32'sd0) ? v : 32'sd0;
    endfunction

    // max(0, min(p, -m)) on a widened word
    function automatic logic signed [33:0] clamp_term(input logic signed [33:0] p,
                                                      input logic signed [31:0] m);
        logic signed [33:0] nm;
        logic signed [33:0] mn;
        nm = -34'(m);
        mn = (p < nm) ? p : nm;
        return (mn < 34'sd0) ? 34'sd0 : mn;
    endfunction

endpackage

`default_nettype wire

@@ sv/lcfdu_ctrl.sv @@
// controller state machine sequencing read, update, rescan and result load
`default_nettype none

module lcfdu_ctrl
    import lcfdu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_STAT;
            end
            ST_STAT:
            begin
                cmd.stat   = 1'b1;
                state_next = status.need_scan ? ST_SCAN : ST_BOUND;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_BOUND;
            end
            ST_BOUND:
            begin
                if (status.out_free)
                begin
                    cmd.bound  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/lcfdu_datapath.sv @@
// cost memories, running statistics, max rescan and output register
`default_nettype none

module lcfdu_datapath
    import lcfdu_pkg::*;
#(
    parameter int MAX_CUT_EDGES    = MAX_CUT_EDGES_DEF,
    parameter int MAX_LIFTED_EDGES = MAX_LIFTED_EDGES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic [1:0]         opcode,
    input  wire logic [3:0]         edge_index,
    input  wire logic signed [31:0] message,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_index,
    input  wire logic [4:0]         cfg_data,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic signed [31:0]      breakpoint_value,
    output logic signed [31:0]      lower_bound,
    output logic                    saturated
);

    localparam int CIW = (MAX_CUT_EDGES > 1) ? $clog2(MAX_CUT_EDGES) : 1;
    localparam int LIW = (MAX_LIFTED_EDGES > 1) ? $clog2(MAX_LIFTED_EDGES) : 1;
    localparam int CPW = $clog2(MAX_CUT_EDGES + 1);

    // configuration
    logic [4:0] cut_cnt_reg;
    logic [4:0] lift_cnt_reg;

    // item registers
    logic [1:0]         op_reg;
    logic [3:0]         idx_reg;
    logic signed [31:0] msg_reg;
    logic               inr_reg;
    logic signed [31:0] cost_reg;
    logic signed [31:0] nv_reg;
    logic signed [33:0] t_reg;
    logic signed [33:0] bp_reg;
    logic               sat_reg;

    // statistics
    logic signed [31:0] mx_reg;
    logic signed [31:0] negc_reg;
    logic signed [31:0] negl_reg;
    logic signed [31:0] posl_reg;

    // rescan
    logic signed [31:0] mx_scan_reg;
    logic [CPW-1:0]     ptr_reg;
    logic [CPW-1:0]     tag_reg;
    logic               pend_reg;

    // cost memories
    logic signed [31:0]          cut_mem [MAX_CUT_EDGES];
    logic signed [31:0]          lift_mem [MAX_LIFTED_EDGES];
    logic [MAX_CUT_EDGES-1:0]    cut_vld_reg;
    logic [MAX_LIFTED_EDGES-1:0] lift_vld_reg;
    logic signed [31:0]          cut_rd_reg;
    logic                        cut_rdv_reg;
    logic signed [31:0]          lift_rd_reg;
    logic                        lift_rdv_reg;

    // output word
    logic               out_valid_reg;
    logic signed [31:0] bpo_reg;
    logic signed [31:0] lbo_reg;
    logic               sato_reg;

    logic [CNT_W-1:0]   n_cut;
    logic [CNT_W-1:0]   n_lift;
    logic [CNT_W-1:0]   in_idx_wide;
    logic [CNT_W-1:0]   idx_wide;
    logic [CIW-1:0]     cut_raddr;
    logic [CIW-1:0]     cut_waddr;
    logic [LIW-1:0]     lift_addr;
    logic               cut_we;
    logic               lift_we;
    logic signed [31:0] cut_val;
    logic signed [31:0] lift_val;
    logic signed [31:0] rd_c;
    logic signed [33:0] sum_add;
    logic               upd;
    logic signed [33:0] negc_sum;
    logic signed [33:0] negl_sum;
    logic signed [33:0] posl_sum;
    logic signed [33:0] bp_cut;
    logic signed [33:0] lift_mn;
    logic signed [33:0] bp_lift;
    logic signed [33:0] bp_fix;
    logic signed [33:0] lb_sum;
    logic               need_scan;
    logic               scan_hit;

    always_comb
    begin
        if (cut_cnt_reg == 5'd0)
            n_cut = CNT_W'(1);
        else if (CNT_W'(cut_cnt_reg) > CNT_W'(MAX_CUT_EDGES))
            n_cut = CNT_W'(MAX_CUT_EDGES);
        else
            n_cut = CNT_W'(cut_cnt_reg);

        if (CNT_W'(lift_cnt_reg) > CNT_W'(MAX_LIFTED_EDGES))
            n_lift = CNT_W'(MAX_LIFTED_EDGES);
        else
            n_lift = CNT_W'(lift_cnt_reg);
    end

    assign in_idx_wide = CNT_W'(edge_index);
    assign idx_wide    = CNT_W'(idx_reg);
    assign cut_waddr   = idx_wide[CIW-1:0];
    assign cut_raddr   = cmd.scan ? ptr_reg[CIW-1:0] : idx_wide[CIW-1:0];
    assign lift_addr   = idx_wide[LIW-1:0];
    assign cut_we      = cmd.stat && inr_reg && (op_reg == OP_CUT_UPD);
    assign lift_we     = cmd.stat && inr_reg && (op_reg == OP_LIFT_UPD);

    // entries never written read as zero
    assign cut_val  = cut_rdv_reg ? cut_rd_reg : 32'sd0;
    assign lift_val = lift_rdv_reg ? lift_rd_reg : 32'sd0;

    assign rd_c    = ((op_reg == OP_LIFT_UPD) || (op_reg == OP_LIFT_BP)) ? lift_val : cut_val;
    assign sum_add = 34'(rd_c) + 34'(msg_reg);
    assign upd     = inr_reg && ((op_reg == OP_CUT_UPD) || (op_reg == OP_LIFT_UPD));

    assign negc_sum = 34'(negc_reg) - 34'(min0(cost_reg)) + 34'(min0(nv_reg));
    assign negl_sum = 34'(negl_reg) - 34'(min0(cost_reg)) + 34'(min0(nv_reg));
    assign posl_sum = 34'(posl_reg) - 34'(max0(cost_reg)) + 34'(max0(nv_reg));

    assign bp_cut  = 34'(cost_reg) + clamp_term(34'(posl_reg), mx_reg);
    assign lift_mn = clamp_term(t_reg, mx_reg);
    assign bp_lift = 34'(cost_reg) + 34'(min0(mx_reg)) + lift_mn;
    assign bp_fix  = 34'(cost_reg) + clamp_term(34'(posl_reg), mx_scan_reg);
    assign lb_sum  = 34'(negc_reg) + 34'(negl_reg) + clamp_term(34'(posl_reg), mx_reg);

    // cut max falls, or queried edge holds the max that bounds the term
    assign need_scan = inr_reg &&
        (((op_reg == OP_CUT_UPD) && !(nv_reg > mx_reg) && (cost_reg == mx_reg)
          && (msg_reg < 32'sd0)) ||
         ((op_reg == OP_CUT_BP) && !((cost_reg < mx_reg)
          || (34'(posl_reg) <= -34'(mx_reg)))));

    assign scan_hit = pend_reg
        && !((op_reg == OP_CUT_BP) && (CNT_W'(tag_reg) == idx_wide))
        && (cut_val > mx_scan_reg);

    assign status.need_scan = need_scan;
    assign status.scan_last = (CNT_W'(ptr_reg) + CNT_W'(1)) == n_cut;
    assign status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cut_we)
        begin
            cut_mem[cut_waddr] <= nv_reg;
        end
        if (cmd.read || cmd.scan)
        begin
            cut_rd_reg <= cut_mem[cut_raddr];
        end
        if (lift_we)
        begin
            lift_mem[lift_addr] <= nv_reg;
        end
        if (cmd.read)
        begin
            lift_rd_reg <= lift_mem[lift_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_cnt_reg   <= 5'd1;
            lift_cnt_reg  <= 5'd0;
            cut_vld_reg   <= '0;
            lift_vld_reg  <= '0;
            cut_rdv_reg   <= 1'b0;
            lift_rdv_reg  <= 1'b0;
            mx_reg        <= 32'sd0;
            negc_reg      <= 32'sd0;
            negl_reg      <= 32'sd0;
            posl_reg      <= 32'sd0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_CUT_COUNT:  cut_cnt_reg  <= cfg_data;
                    CFG_LIFT_COUNT: lift_cnt_reg <= cfg_data;
                    default:        cut_cnt_reg  <= cut_cnt_reg;
                endcase
            end
            if (cmd.read || cmd.scan)
            begin
                cut_rdv_reg <= cut_vld_reg[cut_raddr];
            end
            if (cmd.read)
            begin
                lift_rdv_reg <= lift_vld_reg[lift_addr];
            end
            if (cut_we)
            begin
                cut_vld_reg[cut_waddr] <= 1'b1;
                negc_reg <= clip34(negc_sum);
                if (nv_reg > mx_reg)
                begin
                    mx_reg <= nv_reg;
                end
            end
            if (lift_we)
            begin
                lift_vld_reg[lift_addr] <= 1'b1;
                negl_reg <= clip34(negl_sum);
                posl_reg <= clip34(posl_sum);
            end
            if (cmd.fix && (op_reg == OP_CUT_UPD))
            begin
                mx_reg <= mx_scan_reg;
            end
            pend_reg <= cmd.scan;
            if (cmd.bound)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            idx_reg <= edge_index;
            msg_reg <= message;
            if ((opcode == OP_CUT_UPD) || (opcode == OP_CUT_BP))
                inr_reg <= in_idx_wide < n_cut;
            else
                inr_reg <= in_idx_wide < n_lift;
        end
        if (cmd.add)
        begin
            cost_reg <= rd_c;
            nv_reg   <= clip34(sum_add);
            sat_reg  <= upd && ovf34(sum_add);
            t_reg    <= 34'(posl_reg) - 34'(max0(rd_c));
            bp_reg   <= '0;
        end
        if (cmd.stat)
        begin
            if (inr_reg)
            begin
                unique case (op_reg)
                    OP_CUT_UPD:  sat_reg <= sat_reg | ovf34(negc_sum);
                    OP_LIFT_UPD: sat_reg <= sat_reg | ovf34(negl_sum) | ovf34(posl_sum);
                    OP_CUT_BP:   bp_reg  <= bp_cut;
                    OP_LIFT_BP:  bp_reg  <= bp_lift;
                    default:     bp_reg  <= '0;
                endcase
            end
            if (need_scan)
            begin
                ptr_reg     <= '0;
                mx_scan_reg <= Q_MIN;
            end
        end
        if (cmd.scan)
        begin
            ptr_reg <= ptr_reg + 1'b1;
            tag_reg <= ptr_reg;
        end
        if (scan_hit)
        begin
            mx_scan_reg <= cut_val;
        end
        if (cmd.fix && (op_reg == OP_CUT_BP))
        begin
            bp_reg <= bp_fix;
        end
        if (cmd.bound)
        begin
            bpo_reg  <= clip34(bp_reg);
            lbo_reg  <= clip34(lb_sum);
            sato_reg <= sat_reg | ovf34(bp_reg) | ovf34(lb_sum);
        end
    end

    assign out_valid        = out_valid_reg;
    assign breakpoint_value = bpo_reg;
    assign lower_bound      = lbo_reg;
    assign saturated        = sato_reg;

endmodule

`default_nettype wire

@@ sv/lifted_cut_factor_dual_update_top.sv @@
// top level of the lifted cut factor dual update block
//
// input channel in_valid/in_ready carries one word: opcode, edge_index, message.
// output channel out_valid/out_ready carries one word per input word:
// breakpoint_value, lower_bound, saturated.
// config channel cfg_valid/cfg_ready (always ready) writes cut_edge_count
// (index 0) or lifted_edge_count (index 1) from cfg_data; write only when idle.
// a word passes through the read, add, stat and bound states to out_valid;
// when the cut maximum must be rescanned, scan, scan end and fix lie between
// stat and bound, one cost read per cycle over the n cut edges in use through
// the single cut memory read port; a new word is taken only back in idle.
// the result sits in an output register, so the next word is accepted while
// it waits; a stalled receiver holds the block only once the next result is
// ready to load.
// reset clears costs (via valid bits), statistics and counts (cut 1, lifted 0).
`default_nettype none

module lifted_cut_factor_dual_update_top
    import lcfdu_pkg::*;
#(
    parameter int MAX_CUT_EDGES    = MAX_CUT_EDGES_DEF,
    parameter int MAX_LIFTED_EDGES = MAX_LIFTED_EDGES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         opcode,
    input  wire logic [3:0]         edge_index,
    input  wire logic signed [31:0] message,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      breakpoint_value,
    output logic signed [31:0]      lower_bound,
    output logic                    saturated,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [4:0]         cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    lcfdu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lcfdu_datapath #(
        .MAX_CUT_EDGES    (MAX_CUT_EDGES),
        .MAX_LIFTED_EDGES (MAX_LIFTED_EDGES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .opcode           (opcode),
        .edge_index       (edge_index),
        .message          (message),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .breakpoint_value (breakpoint_value),
        .lower_bound      (lower_bound),
        .saturated        (saturated)
    );

    // busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("block still ready after accepting a word");

    // a new result only comes out of a busy block
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

    // returning to idle always leaves a result behind
    a_idle_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
        else $error("went idle without a result");

endmodule

`default_nettype wire

@@ tb/lifted_cut_factor_dual_update_top_tb.sv @@
// testbench for the lifted cut factor dual update block with an inline predictor
`timescale 1ns / 1ps

module lifted_cut_factor_dual_update_top_tb
    import lcfdu_pkg::*;
();

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         idx;
        logic signed [31:0] msg;
    } edge_word_t;

    typedef struct packed {
        logic signed [31:0] breakpoint;
        logic signed [31:0] bound;
        logic               clipped;
    } factor_result_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode = OP_CUT_UPD;
    logic [3:0]         edge_index = 4'd0;
    logic signed [31:0] message = 32'sd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] breakpoint_value;
    logic signed [31:0] lower_bound;
    logic               saturated;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = CFG_CUT_COUNT;
    logic [4:0]         cfg_data = 5'd0;

    // predictor state
    logic signed [31:0] cut_cost [MAX_CUT_EDGES_DEF];
    logic signed [31:0] lift_cost [MAX_LIFTED_EDGES_DEF];
    logic signed [31:0] largest_cut = 32'sd0;
    logic signed [31:0] cut_neg_sum = 32'sd0;
    logic signed [31:0] lift_neg_sum = 32'sd0;
    logic signed [31:0] lift_pos_sum = 32'sd0;
    logic [4:0]         cut_count_reg = 5'd1;
    logic [4:0]         lift_count_reg = 5'd0;

    edge_word_t     queued_words[$];
    factor_result_t predicted_outputs[$];
    edge_word_t     next_word;
    factor_result_t want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    logic hold_low = 1'b0;
    bit holdoff_go = 1'b0;

    lifted_cut_factor_dual_update_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .edge_index       (edge_index),
        .message          (message),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .breakpoint_value (breakpoint_value),
        .lower_bound      (lower_bound),
        .saturated        (saturated),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint lmin(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [31:0] clip_q(input longint v, inout bit clipped);
        if (v > longint'(Q_MAX))
        begin
            clipped = 1'b1;
            return Q_MAX;
        end
        if (v < longint'(Q_MIN))
        begin
            clipped = 1'b1;
            return Q_MIN;
        end
        return 32'(v);
    endfunction

    function automatic int cuts_active();
        if (cut_count_reg < 5'd1)
            return 1;
        if (cut_count_reg > 5'(MAX_CUT_EDGES_DEF))
            return MAX_CUT_EDGES_DEF;
        return int'(cut_count_reg);
    endfunction

    function automatic int lifted_active();
        if (lift_count_reg > 5'(MAX_LIFTED_EDGES_DEF))
            return MAX_LIFTED_EDGES_DEF;
        return int'(lift_count_reg);
    endfunction

    function automatic longint forced_term(input longint pos, input longint mx);
        return lmax(0, lmin(pos, -mx));
    endfunction

    function automatic longint cut_scan_max(input int skip);
        longint m;
        m = longint'(Q_MIN);
        for (int i = 0; i < cuts_active(); i++)
            if (i != skip && longint'(cut_cost[i]) > m)
                m = cut_cost[i];
        return m;
    endfunction

    function automatic factor_result_t apply_dual_update(input edge_word_t w);
        bit             clipped;
        longint         bp;
        longint         mx;
        longint         pos;
        longint         msg;
        longint         old_c;
        longint         new_c;
        int             idx;
        factor_result_t r;
        clipped = 1'b0;
        bp = 0;
        mx = largest_cut;
        pos = lift_pos_sum;
        msg = w.msg;
        idx = int'(w.idx);
        case (w.op)
            OP_CUT_UPD:
            begin
                if (idx < cuts_active())
                begin
                    old_c = cut_cost[idx];
                    new_c = clip_q(old_c + msg, clipped);
                    cut_cost[idx] = 32'(new_c);
                    cut_neg_sum = clip_q(longint'(cut_neg_sum) - lmin(0, old_c)
                                         + lmin(0, new_c), clipped);
                    if (new_c > mx)
                        largest_cut = 32'(new_c);
                    else if (old_c == mx && msg < 0)
                        largest_cut = 32'(cut_scan_max(-1));
                end
            end
            OP_LIFT_UPD:
            begin
                if (idx < lifted_active())
                begin
                    old_c = lift_cost[idx];
                    new_c = clip_q(old_c + msg, clipped);
                    lift_cost[idx] = 32'(new_c);
                    lift_neg_sum = clip_q(longint'(lift_neg_sum) - lmin(0, old_c)
                                          + lmin(0, new_c), clipped);
                    lift_pos_sum = clip_q(longint'(lift_pos_sum) - lmax(0, old_c)
                                          + lmax(0, new_c), clipped);
                end
            end
            OP_CUT_BP:
            begin
                if (idx < cuts_active())
                begin
                    old_c = cut_cost[idx];
                    if (old_c < mx || pos <= -mx)
                        bp = old_c + forced_term(pos, mx);
                    else
                        bp = old_c + forced_term(pos, cut_scan_max(idx));
                end
            end
            default:
            begin
                if (idx < lifted_active())
                begin
                    old_c = lift_cost[idx];
                    bp = old_c + lmin(0, mx) + lmax(0, lmin(pos - lmax(0, old_c), -mx));
                end
            end
        endcase
        r.breakpoint = clip_q(bp, clipped);
        r.bound = clip_q(longint'(cut_neg_sum) + longint'(lift_neg_sum)
                         + forced_term(lift_pos_sum, largest_cut), clipped);
        r.clipped = clipped;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] wanted);
        mismatch_count++;
        $display("%0t mismatch %s: got %h expected %h", $time, field, got, wanted);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predicted_outputs.insert(predicted_outputs.size(), apply_dual_update(
                    edge_word_t'{opcode, edge_index, message}));
            if (!in_valid || in_ready)
            begin
                if (queued_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_word = queued_words.pop_front();
                    in_valid <= 1'b1;
                    opcode <= next_word.op;
                    edge_index <= next_word.idx;
                    message <= next_word.msg;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_low && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_outputs.size() == 0)
            begin
                report_mismatch("unexpected word", breakpoint_value, 32'd0);
            end
            else
            begin
                want = predicted_outputs.pop_front();
                if (breakpoint_value !== want.breakpoint)
                    report_mismatch("breakpoint_value", breakpoint_value, want.breakpoint);
                if (lower_bound !== want.bound)
                    report_mismatch("lower_bound", lower_bound, want.bound);
                if (saturated !== want.clipped)
                    report_mismatch("saturated", 32'(saturated), 32'(want.clipped));
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (holdoff_go);
        @(posedge clk);
        hold_low <= 1'b1;
        repeat (400) @(posedge clk);
        hold_low <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic queue_word(input logic [1:0] op, input logic [3:0] idx,
                              input logic signed [31:0] msg);
        queued_words.insert(queued_words.size(), edge_word_t'{op, idx, msg});
    endtask

    function automatic logic signed [31:0] rand_message();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3: return $urandom;
            default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        endcase
    endfunction

    task automatic queue_random_words(input int count);
        logic [1:0] op;
        logic [3:0] idx;
        int         n;
        for (int k = 0; k < count; k++)
        begin
            op = 2'($urandom_range(0, 3));
            n = (op == OP_CUT_UPD || op == OP_CUT_BP) ? cuts_active() : lifted_active();
            if (n == 0 || $urandom_range(0, 9) == 0)
                idx = 4'($urandom);
            else
                idx = 4'($urandom_range(0, n - 1));
            queue_word(op, idx, rand_message());
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (queued_words.size() != 0 || in_valid || predicted_outputs.size() != 0);
    endtask

    task automatic write_count(input logic idx, input logic [4:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_CUT_COUNT)
            cut_count_reg = value;
        else
            lift_count_reg = value;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int cut_cfg [8];
        int lift_cfg [8];
        cut_cfg = '{16, 8, 1, 0, 31, 3, 16, 5};
        lift_cfg = '{16, 5, 0, 31, 17, 1, 0, 16};
        for (int i = 0; i < MAX_CUT_EDGES_DEF; i++)
            cut_cost[i] = 32'sd0;
        for (int i = 0; i < MAX_LIFTED_EDGES_DEF; i++)
            lift_cost[i] = 32'sd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        drain();

        // directed: saturation at the extremes, rescans, every opcode
        write_count(CFG_CUT_COUNT, 5'd16);
        write_count(CFG_LIFT_COUNT, 5'd16);
        queue_word(OP_CUT_UPD, 4'd0, Q_MAX);
        queue_word(OP_CUT_UPD, 4'd0, Q_MAX);
        queue_word(OP_CUT_UPD, 4'd1, Q_MIN);
        queue_word(OP_CUT_UPD, 4'd2, Q_MIN);
        queue_word(OP_LIFT_UPD, 4'd0, Q_MAX);
        queue_word(OP_LIFT_UPD, 4'd1, Q_MAX);
        queue_word(OP_LIFT_UPD, 4'd2, Q_MIN);
        queue_word(OP_LIFT_UPD, 4'd3, Q_MIN);
        queue_word(OP_CUT_BP, 4'd0, 32'sd0);
        queue_word(OP_CUT_BP, 4'd1, 32'sd0);
        queue_word(OP_LIFT_BP, 4'd0, 32'sd0);
        queue_word(OP_LIFT_BP, 4'd2, 32'sd0);
        queue_word(OP_CUT_UPD, 4'd0, Q_MIN);
        queue_word(OP_CUT_UPD, 4'd0, 32'sh0001_0000);
        queue_word(OP_CUT_BP, 4'd15, 32'sd0);
        queue_word(OP_LIFT_BP, 4'd15, 32'sd0);
        queue_word(OP_CUT_UPD, 4'd15, 32'sh7fff_0000);
        queue_word(OP_CUT_BP, 4'd15, 32'sd0);
        drain();

        // single cut edge excluded, lifted set empty, indexes out of range
        write_count(CFG_CUT_COUNT, 5'd1);
        write_count(CFG_LIFT_COUNT, 5'd0);
        queue_word(OP_CUT_UPD, 4'd0, Q_MAX);
        queue_word(OP_CUT_BP, 4'd0, 32'sd0);
        queue_word(OP_CUT_UPD, 4'd9, 32'sh0003_0000);
        queue_word(OP_LIFT_UPD, 4'd0, 32'sh0003_0000);
        queue_word(OP_CUT_BP, 4'd9, 32'sd0);
        queue_word(OP_LIFT_BP, 4'd4, 32'sd0);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            write_count(CFG_CUT_COUNT, 5'(cut_cfg[p]));
            write_count(CFG_LIFT_COUNT, 5'(lift_cfg[p]));
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 62;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 62;
                end
                default:
                begin
                    send_idle_pct = 13;
                    recv_stall_pct = 13;
                end
            endcase
            queue_random_words(166);
            if (p == 4)
                holdoff_go = 1'b1;
            drain();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
